/* rtl/telemetry_command_frame_receiver_macros.svh */
// Assertion macros for the frame receiver.
`ifndef TELEMETRY_COMMAND_FRAME_RECEIVER_MACROS_SVH
`define TELEMETRY_COMMAND_FRAME_RECEIVER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge outside reset.
`define TCFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define TCFR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define TCFR_ASSERT(label, prop, msg)
`define TCFR_ASSERT_IMPLY(label, ante, cons, msg)

`endif

`endif

/* rtl/tcfr_pkg.sv */
package tcfr_pkg;

    // Frame bytes and function codes
    localparam logic [7:0] HDR_FIRST   = 8'hAA;
    localparam logic [7:0] HDR_SECOND  = 8'hAF;
    localparam logic [7:0] FN_LIMIT    = 8'hF1;
    localparam logic [7:0] ACK_ID      = 8'hEF;
    localparam logic [7:0] ACK_LEN     = 8'h02;
    localparam logic [7:0] FN_REQ      = 8'h02;
    localparam logic [7:0] FN_GAIN_A   = 8'h10;
    localparam logic [7:0] FN_GAIN_B   = 8'h11;
    localparam logic [7:0] FN_ACK_LAST = 8'h15;
    localparam logic [7:0] REQ_VERSION = 8'hA0;
    localparam logic [7:0] REQ_DUMP    = 8'h01;

    localparam int LEN_LIMIT   = 50;
    localparam int STORE_DEPTH = 18;
    localparam int STORE_IW    = $clog2(STORE_DEPTH);
    localparam int GAIN_WORDS  = 9;
    localparam int NEG_WORDS   = 3;
    localparam int ACK_BYTES   = 7;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Sum of the four fixed leading bytes of the acknowledge frame
    localparam logic [7:0] ACK_SUM_BASE = 8'(HDR_FIRST + HDR_FIRST + ACK_ID + ACK_LEN);

    // Result kinds
    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_GAIN    = 2'd1;
    localparam logic [1:0] KIND_DUMP    = 2'd2;
    localparam logic [1:0] KIND_VERSION = 2'd3;

    typedef logic [STORE_DEPTH-1:0][7:0] payload_t;

    // One checked frame waiting to be carried out
    typedef struct packed {
        logic [7:0] fn;
        logic [7:0] sum;
        payload_t   payload;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

/* rtl/tcfr_byte_if.sv */
interface tcfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/tcfr_result_if.sv */
interface tcfr_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [7:0]         ack_byte;
    logic [4:0]         gain_index;
    logic signed [16:0] gain_value;
    logic               last;

    modport source (output valid, output kind, output ack_byte, output gain_index,
                    output gain_value, output last, input ready);
    modport sink (input valid, input kind, input ack_byte, input gain_index,
                  input gain_value, input last, output ready);
endinterface

/* rtl/tcfr_front.sv */
module tcfr_front
    import tcfr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tcfr_byte_if.sink     rx,
    input  queue_status_t q_status,
    output logic          q_push,
    output job_t          q_job
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_HDR2 = 3'd2;
    localparam logic [2:0] PH_FUNC = 3'd3;
    localparam logic [2:0] PH_PAY  = 3'd4;
    localparam logic [2:0] PH_CHK  = 3'd5;

    localparam logic [7:0] LEN_LIMIT_B = 8'(LEN_LIMIT);

    logic [2:0] phase_reg, phase_next;
    logic [5:0] rem_reg, rem_next;
    logic [5:0] count_reg, count_next;
    logic [7:0] fn_reg, fn_next;
    logic [7:0] sum_reg, sum_next;
    payload_t   store_reg, store_next;
    logic       accept;
    logic       wanted;
    logic [7:0] b;

    assign rx.ready = !q_status.full;
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.rx_byte;

    // Only frames that lead to at least one result go to the queue.
    assign wanted = (fn_reg == FN_REQ && (store_reg[0] == REQ_DUMP || store_reg[0] == REQ_VERSION))
                 || (fn_reg >= FN_GAIN_A && fn_reg <= FN_ACK_LAST);

    always_comb
    begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        fn_next    = fn_reg;
        sum_next   = sum_reg;
        store_next = store_reg;
        q_push     = 1'b0;
        if (accept)
        begin
            phase_next = PH_IDLE;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (b == HDR_FIRST)
                    begin
                        phase_next = PH_HDR1;
                        sum_next   = b;
                    end
                end
                PH_HDR1:
                begin
                    if (b == HDR_SECOND)
                    begin
                        phase_next = PH_HDR2;
                        sum_next   = sum_reg + b;
                    end
                end
                PH_HDR2:
                begin
                    if (b < FN_LIMIT)
                    begin
                        phase_next = PH_FUNC;
                        fn_next    = b;
                        sum_next   = sum_reg + b;
                    end
                end
                PH_FUNC:
                begin
                    if (b < LEN_LIMIT_B)
                    begin
                        phase_next = PH_PAY;
                        rem_next   = b[5:0];
                        count_next = '0;
                        sum_next   = sum_reg + b;
                    end
                end
                PH_PAY:
                begin
                    if (rem_reg != '0)
                    begin
                        if (count_reg < 6'(STORE_DEPTH))
                        begin
                            store_next[count_reg[STORE_IW-1:0]] = b;
                        end
                        count_next = count_reg + 6'd1;
                        sum_next   = sum_reg + b;
                        rem_next   = rem_reg - 6'd1;
                        phase_next = (rem_reg == 6'd1) ? PH_CHK : PH_PAY;
                    end
                end
                PH_CHK:
                begin
                    q_push = (b == sum_reg) && wanted;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    assign q_job.fn      = fn_reg;
    assign q_job.sum     = sum_reg;
    assign q_job.payload = store_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            rem_reg   <= '0;
            count_reg <= '0;
            fn_reg    <= '0;
            sum_reg   <= '0;
            store_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            count_reg <= count_next;
            fn_reg    <= fn_next;
            sum_reg   <= sum_next;
            store_reg <= store_next;
        end
    end

endmodule

/* rtl/tcfr_queue.sv */
module tcfr_queue
    import tcfr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  job_t          push_job,
    input  logic          pop,
    output job_t          head,
    output queue_status_t status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        wrap_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/tcfr_back.sv */
module tcfr_back
    import tcfr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  job_t          head,
    input  queue_status_t q_status,
    output logic          pop,
    tcfr_result_if.source res
);

    logic [3:0]         step_reg, step_next;
    logic               valid_reg;
    logic [1:0]         kind_reg, kind_d;
    logic [7:0]         ack_reg, ack_d;
    logic [4:0]         idx_reg, idx_d;
    logic signed [16:0] val_reg, val_d;
    logic               last_reg, last_d;

    logic               is_req, is_gain, neg, in_gain, issue;
    logic [2:0]         ack_step;
    logic [STORE_IW-1:0] hi_idx, lo_idx;
    logic [15:0]        word;
    logic signed [16:0] word_x;

    always_comb
    begin
        is_req   = (head.fn == FN_REQ);
        neg      = (head.fn == FN_GAIN_B);
        is_gain  = (head.fn == FN_GAIN_A) || neg;
        in_gain  = is_gain && (step_reg < 4'(GAIN_WORDS));
        ack_step = is_gain ? 3'(step_reg - 4'(GAIN_WORDS)) : step_reg[2:0];
        hi_idx   = STORE_IW'({step_reg, 1'b0});
        lo_idx   = STORE_IW'({step_reg, 1'b1});
        word     = {head.payload[hi_idx], head.payload[lo_idx]};
        word_x   = {word[15], word};

        kind_d = KIND_ACK;
        ack_d  = '0;
        idx_d  = '0;
        val_d  = '0;
        last_d = 1'b0;
        if (is_req)
        begin
            kind_d = (head.payload[0] == REQ_DUMP) ? KIND_DUMP : KIND_VERSION;
            last_d = 1'b1;
        end
        else if (in_gain)
        begin
            kind_d = KIND_GAIN;
            idx_d  = neg ? 5'(GAIN_WORDS) + 5'(step_reg) : 5'(step_reg);
            val_d  = (neg && step_reg < 4'(NEG_WORDS)) ? -word_x : word_x;
        end
        else
        begin
            case (ack_step)
                3'd0:    ack_d = HDR_FIRST;
                3'd1:    ack_d = HDR_FIRST;
                3'd2:    ack_d = ACK_ID;
                3'd3:    ack_d = ACK_LEN;
                3'd4:    ack_d = head.fn;
                3'd5:    ack_d = head.sum;
                default: ack_d = ACK_SUM_BASE + head.fn + head.sum;
            endcase
            last_d = (ack_step == 3'(ACK_BYTES - 1));
        end
    end

    // Issue one result whenever a job is waiting and the output stage is empty or being drained.
    assign issue     = !q_status.empty && (!valid_reg || res.ready);
    assign pop       = issue && last_d;
    assign step_next = issue ? (last_d ? '0 : step_reg + 4'd1) : step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (!valid_reg || res.ready)
            begin
                valid_reg <= issue;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            kind_reg <= kind_d;
            ack_reg  <= ack_d;
            idx_reg  <= idx_d;
            val_reg  <= val_d;
            last_reg <= last_d;
        end
    end

    assign res.valid      = valid_reg;
    assign res.kind       = kind_reg;
    assign res.ack_byte   = ack_reg;
    assign res.gain_index = idx_reg;
    assign res.gain_value = val_reg;
    assign res.last       = last_reg;

endmodule

/* rtl/telemetry_command_frame_receiver.sv */
// Command frame receiver for a byte-serial telemetry link.
// rx carries one received byte per item; res carries result items: acknowledge
// bytes, gain updates and request events, with last marking the final result
// of the byte that closed a frame.
// Frames are AA AF, function, length, payload, additive checksum. The front
// parser takes one byte every cycle while the job queue has room; a checked
// frame that yields results is snapshotted (function, checksum, 18 payload
// bytes) into a short job queue. The back sequencer drains the head job at
// one result per cycle while res is ready: 1 for a request, 7 for an
// acknowledge, 16 for a gain frame. A frame's job is queued when its checksum
// byte is taken; its first result then goes through the output register.
// rx.ready drops only while the job queue is full, so the byte rate is one
// per cycle until the sequencer falls behind. When res stalls, the output
// register holds its item and the sequencer waits; the parser keeps taking
// bytes until the queue fills. Reset clears the parser to idle with a
// zeroed payload store, empties the queue and drops any pending result.
`include "telemetry_command_frame_receiver_macros.svh"

module telemetry_command_frame_receiver
    import tcfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    tcfr_byte_if.sink     rx,
    tcfr_result_if.source res
);

    logic          q_push;
    logic          q_pop;
    job_t          q_job;
    job_t          q_head;
    queue_status_t q_status;

    // Parse bytes, keep the payload store, hand over checked frames.
    tcfr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .q_status (q_status),
        .q_push   (q_push),
        .q_job    (q_job)
    );

    // Hold frames between parser and sequencer.
    tcfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head     (q_head),
        .status   (q_status)
    );

    // Expand each job into its result items.
    tcfr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .q_status (q_status),
        .pop      (q_pop),
        .res      (res)
    );

    `TCFR_ASSERT_IMPLY(a_no_push_full, q_push, !q_status.full, "job pushed into a full queue")
    `TCFR_ASSERT_IMPLY(a_no_pop_empty, q_pop, !q_status.empty, "job popped from an empty queue")
    `TCFR_ASSERT_IMPLY(a_req_last, res.valid && (res.kind == KIND_DUMP || res.kind == KIND_VERSION), res.last, "request event not final")
    `TCFR_ASSERT_IMPLY(a_gain_not_last, res.valid && res.kind == KIND_GAIN, !res.last && res.gain_index <= 5'd17, "gain item marked final or slot out of range")

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import tcfr_pkg::*;

    // Parser phases of the local frame decoder
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_GOT_AA,
        PH_GOT_AF,
        PH_GOT_FN,
        PH_PAYLOAD,
        PH_CHECK
    } rx_phase_e;

    // One result item as the block should present it
    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         ack_byte;
        logic [4:0]         gain_index;
        logic signed [16:0] gain_value;
        logic               last;
    } frame_output_t;

    // Run limits. The slowest correct run is a few hundred bytes, each possibly
    // idled on the sender, up to 16 results per closing byte, each possibly
    // waiting out a receiver stall, plus one long receiver hold-off.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AT_BYTES = 40;
    localparam int CALM_BYTES    = 40;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_BYTES  = 30;

    logic clk = 1'b0;
    logic rst_n;

    tcfr_byte_if   rx_if ();
    tcfr_result_if res_if ();

    telemetry_command_frame_receiver dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .res   (res_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bytes still to be offered, and results the decoder says must come out
    logic [7:0]    tx_bytes [$];
    frame_output_t outputs_due [$];
    logic [7:0]    body_q [$];

    // Local frame decoder state
    rx_phase_e  dec_phase;
    logic [5:0] dec_left;
    logic [5:0] dec_count;
    logic [7:0] dec_fn;
    logic [7:0] dec_sum;
    logic [7:0] dec_store [STORE_DEPTH];

    int  error_count = 0;
    int  cycle_count = 0;
    int  bytes_taken = 0;
    int  hold_at     = 0;
    bit  rx_taken    = 1'b0;
    int  gap_left    = 0;
    int  stall_left  = 0;
    int  hold_left   = 0;
    bit  hold_done   = 1'b0;

    // ------------------------------------------------------------------
    // Frame decoder: mirrors the block byte by byte and queues the results
    // ------------------------------------------------------------------

    function automatic void add_output(logic [1:0] kind, logic [7:0] ack,
                                       logic [4:0] idx, logic signed [16:0] val);
        frame_output_t o;
        o.kind       = kind;
        o.ack_byte   = ack;
        o.gain_index = idx;
        o.gain_value = val;
        o.last       = 1'b0;
        outputs_due.push_back(o);
    endfunction

    // Checksum byte arrived: if it matches, emit request, gain words and acknowledge frame
    function automatic void close_frame(logic [7:0] chk);
        int                 n0;
        logic [15:0]        w;
        logic signed [16:0] val;
        logic [7:0]         ack [ACK_BYTES];
        logic [7:0]         ck;
        n0 = outputs_due.size();
        if (chk != dec_sum)
            return;
        if (dec_fn == FN_REQ)
        begin
            if (dec_store[0] == REQ_DUMP)
                add_output(KIND_DUMP, 8'h00, 5'd0, 17'sd0);
            else if (dec_store[0] == REQ_VERSION)
                add_output(KIND_VERSION, 8'h00, 5'd0, 17'sd0);
        end
        if (dec_fn == FN_GAIN_A || dec_fn == FN_GAIN_B)
        begin
            for (int i = 0; i < GAIN_WORDS; i++)
            begin
                // big-endian pair, sign-extended; slots 9..11 flip sign
                w   = {dec_store[2*i], dec_store[2*i+1]};
                val = $signed({w[15], w});
                if (dec_fn == FN_GAIN_B && i < NEG_WORDS)
                    val = -val;
                add_output(KIND_GAIN, 8'h00,
                           5'((dec_fn == FN_GAIN_B ? GAIN_WORDS : 0) + i), val);
            end
        end
        if (dec_fn >= FN_GAIN_A && dec_fn <= FN_ACK_LAST)
        begin
            ack[0] = HDR_FIRST;
            ack[1] = HDR_FIRST;
            ack[2] = ACK_ID;
            ack[3] = ACK_LEN;
            ack[4] = dec_fn;
            ack[5] = dec_sum;
            ck = 8'h00;
            for (int i = 0; i < 6; i++)
                ck = ck + ack[i];
            ack[6] = ck;
            for (int i = 0; i < ACK_BYTES; i++)
                add_output(KIND_ACK, ack[i], 5'd0, 17'sd0);
        end
        if (outputs_due.size() > n0)
            outputs_due[outputs_due.size()-1].last = 1'b1;
    endfunction

    function automatic void decode_rx_byte(logic [7:0] b);
        if (dec_phase == PH_IDLE && b == HDR_FIRST)
        begin
            dec_phase = PH_GOT_AA;
            dec_sum   = b;
        end
        else if (dec_phase == PH_GOT_AA && b == HDR_SECOND)
        begin
            dec_phase = PH_GOT_AF;
            dec_sum   = dec_sum + b;
        end
        else if (dec_phase == PH_GOT_AF && b < FN_LIMIT)
        begin
            dec_phase = PH_GOT_FN;
            dec_fn    = b;
            dec_sum   = dec_sum + b;
        end
        else if (dec_phase == PH_GOT_FN && b < LEN_LIMIT)
        begin
            dec_phase = PH_PAYLOAD;
            dec_left  = b[5:0];
            dec_count = 6'd0;
            dec_sum   = dec_sum + b;
        end
        else if (dec_phase == PH_PAYLOAD && dec_left != 6'd0)
        begin
            // bytes past the store only feed the checksum
            if (dec_count < STORE_DEPTH)
                dec_store[dec_count] = b;
            dec_count = dec_count + 6'd1;
            dec_sum   = dec_sum + b;
            dec_left  = dec_left - 6'd1;
            if (dec_left == 6'd0)
                dec_phase = PH_CHECK;
        end
        else if (dec_phase == PH_CHECK)
        begin
            dec_phase = PH_IDLE;
            close_frame(b);
        end
        else
        begin
            // unfit byte: drop back to idle without looking at it again
            dec_phase = PH_IDLE;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    function automatic void fill_body(int n);
        body_q.delete();
        repeat (n)
            body_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Append AA AF fn len body checksum; optionally corrupt the checksum or
    // cut the frame short after the first keep bytes.
    function automatic void add_frame(logic [7:0] fn, logic [7:0] len_byte,
                                      bit bad_sum, int keep);
        logic [7:0] fr [$];
        logic [7:0] s;
        fr.push_back(HDR_FIRST);
        fr.push_back(HDR_SECOND);
        fr.push_back(fn);
        fr.push_back(len_byte);
        foreach (body_q[i])
            fr.push_back(body_q[i]);
        s = 8'h00;
        foreach (fr[i])
            s = s + fr[i];
        if (bad_sum)
            s = s + 8'($urandom_range(1, 255));
        fr.push_back(s);
        if (keep > 0 && keep < fr.size())
            fr = fr[0:keep-1];
        foreach (fr[i])
            tx_bytes.push_back(fr[i]);
    endfunction

    function automatic void add_good_frame(logic [7:0] fn);
        add_frame(fn, 8'(body_q.size()), 1'b0, 0);
    endfunction

    function automatic void build_directed();
        // request events and the no-result request
        body_q = {REQ_DUMP};
        add_good_frame(FN_REQ);
        body_q = {REQ_VERSION, 8'h00};
        add_good_frame(FN_REQ);
        body_q = {8'h55};
        add_good_frame(FN_REQ);
        // gain words at their extremes: negated first three, plain rest
        body_q = {8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00,
                  8'h7F, 8'hFF, 8'h01, 8'h00, 8'hC3, 8'h3C, 8'h0F, 8'hF0,
                  8'hFF, 8'h00};
        add_good_frame(FN_GAIN_B);
        // short payload: the rest of the store keeps the old bytes
        body_q = {8'h01, 8'h02, 8'h03, 8'h04};
        add_good_frame(FN_GAIN_B);
        // long payload: only the first 18 bytes land in the store
        fill_body(STORE_DEPTH + 2);
        add_good_frame(FN_GAIN_A);
        // acknowledge-only function and other function codes
        fill_body(3);
        add_good_frame(FN_ACK_LAST);
        fill_body(2);
        add_good_frame(8'hF0);
        fill_body(1);
        add_good_frame(8'h00);
        // zero length: the checksum byte falls out as unfit
        body_q.delete();
        add_good_frame(8'h13);
        // checksum failure
        fill_body(4);
        add_frame(FN_GAIN_A, 8'd4, 1'b1, 0);
        // unfit bytes at each phase; the second AA is not a new header
        tx_bytes.push_back(HDR_FIRST);
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(HDR_FIRST);
        tx_bytes.push_back(HDR_FIRST);
        tx_bytes.push_back(HDR_SECOND);
        tx_bytes.push_back(8'hFF);
        fill_body(2);
        add_frame(FN_LIMIT, 8'd2, 1'b0, 0);
        add_frame(FN_GAIN_A, 8'(LEN_LIMIT), 1'b0, 0);
        body_q = {REQ_DUMP};
        add_good_frame(FN_REQ);
    endfunction

    // Mostly well-formed frames with random content, some noise and broken
    // frames; keep going until enough bytes and acknowledge frames are queued.
    function automatic void build_random();
        int start;
        int pick;
        int sel;
        int n;
        int acks;
        logic [7:0] fn;
        start = tx_bytes.size();
        acks  = 0;
        while (tx_bytes.size() - start < RANDOM_BYTES || acks < 2)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 2)
                    fn = FN_REQ;
                else if (sel < 5)
                    fn = FN_GAIN_A;
                else if (sel < 7)
                    fn = FN_GAIN_B;
                else if (sel < 9)
                    fn = 8'($urandom_range(FN_GAIN_B + 1, FN_ACK_LAST));
                else
                    fn = 8'($urandom_range(0, FN_LIMIT - 1));
                if ($urandom_range(0, 19) == 0)
                    n = $urandom_range(19, LEN_LIMIT - 1);
                else if (fn == FN_GAIN_A || fn == FN_GAIN_B)
                    n = ($urandom_range(0, 3) != 0) ? STORE_DEPTH : $urandom_range(1, 24);
                else
                    n = $urandom_range(1, 12);
                fill_body(n);
                if (fn == FN_REQ)
                begin
                    sel = $urandom_range(0, 2);
                    body_q[0] = (sel == 0) ? REQ_DUMP : (sel == 1) ? REQ_VERSION : body_q[0];
                end
                add_good_frame(fn);
                if (fn >= FN_GAIN_A && fn <= FN_ACK_LAST)
                    acks++;
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 4))
                    tx_bytes.push_back(($urandom_range(0, 3) == 0) ? HDR_FIRST
                                                                  : 8'($urandom_range(0, 255)));
            end
            else
            begin
                fill_body($urandom_range(0, STORE_DEPTH));
                fn  = 8'($urandom_range(FN_REQ, FN_ACK_LAST));
                sel = $urandom_range(0, 3);
                case (sel)
                    0: add_frame(fn, 8'(body_q.size()), 1'b1, 0);
                    1: add_frame(fn, 8'(body_q.size()), 1'b0,
                                 $urandom_range(1, body_q.size() + 4));
                    2: add_frame(8'($urandom_range(FN_LIMIT, 255)), 8'(body_q.size()), 1'b0, 0);
                    default: add_frame(fn, 8'($urandom_range(LEN_LIMIT, 255)), 1'b0, 0);
                endcase
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Sample both handshakes at the rising edge. Check the result first, then
    // advance the decoder with the byte just taken.
    always @(posedge clk)
    begin
        frame_output_t want;
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (outputs_due.size() == 0)
                begin
                    $error("result item with nothing expected: kind %0d ack_byte %0d",
                           res_if.kind, res_if.ack_byte);
                    error_count++;
                end
                else
                begin
                    want = outputs_due.pop_front();
                    check_field("kind", want.kind, res_if.kind);
                    check_field("ack_byte", want.ack_byte, res_if.ack_byte);
                    check_field("gain_index", want.gain_index, res_if.gain_index);
                    check_field("gain_value", want.gain_value, res_if.gain_value);
                    check_field("last", want.last, res_if.last);
                end
            end
            if (rx_if.valid && rx_if.ready)
            begin
                decode_rx_byte(rx_if.rx_byte);
                void'(tx_bytes.pop_front());
                rx_taken = 1'b1;
                bytes_taken++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offer the head of tx_bytes, hold it until taken, and idle in
    // random bursts while idling is on and the run is not near its end.
    // ------------------------------------------------------------------

    function automatic bit idling_on();
        // every fourth stretch of cycles runs with no idling at all
        return ((cycle_count / 250) % 4) != 3 && tx_bytes.size() > CALM_BYTES;
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
            rx_if.valid <= 1'b0;
        else if (!rx_if.valid || rx_taken)
        begin
            rx_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                rx_if.valid <= 1'b0;
            end
            else if (idling_on() && $urandom_range(0, 7) == 0)
            begin
                gap_left = $urandom_range(0, 9);
                rx_if.valid <= 1'b0;
            end
            else if (tx_bytes.size() != 0)
            begin
                rx_if.valid   <= 1'b1;
                rx_if.rx_byte <= tx_bytes[0];
            end
            else
                rx_if.valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off so the job queue fills
    // and the block has to drop rx.ready while the sender keeps offering.
    always @(negedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else if (!hold_done && hold_at > 0 && bytes_taken >= hold_at)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            res_if.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            res_if.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            res_if.ready <= 1'b0;
        end
        else if (idling_on() && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 9);
            res_if.ready <= 1'b0;
        end
        else
            res_if.ready <= 1'b1;
    end

    // Hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, queue all bytes, drain, settle, report.
    // ------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        res_if.ready  = 1'b0;

        dec_phase = PH_IDLE;
        dec_left  = 6'd0;
        dec_count = 6'd0;
        dec_fn    = 8'h00;
        dec_sum   = 8'h00;
        foreach (dec_store[i])
            dec_store[i] = 8'h00;

        build_directed();
        // start the long hold-off just before the gain frames pile up
        hold_at = HOLD_AT_BYTES;
        build_random();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait for every byte to be taken and every result to come out
        while (tx_bytes.size() != 0 || outputs_due.size() != 0)
            @(posedge clk);
        // let any stray extra results show up
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

/* telemetry_command_frame_receiver.f */
+incdir+rtl
rtl/tcfr_pkg.sv
rtl/tcfr_byte_if.sv
rtl/tcfr_result_if.sv
rtl/tcfr_front.sv
rtl/tcfr_queue.sv
rtl/tcfr_back.sv
rtl/telemetry_command_frame_receiver.sv
dv/testbench.sv
